>>> hdl/pfsu_pkg.sv
package pfsu_pkg;

    localparam int DATA_W      = 16;
    localparam int INT_BITS    = 6;
    localparam int FRAC_BITS   = DATA_W - INT_BITS;
    localparam int IDX_SHIFT   = (DATA_W - INT_BITS - 6 > 0) ? (DATA_W - INT_BITS - 6) : 0;
    localparam int COARSE_W    = DATA_W - IDX_SHIFT;
    localparam int MAP_ENTRIES = 64;
    localparam int MAP_AW      = $clog2(MAP_ENTRIES);
    localparam int SEGMENTS    = 16;
    localparam int SEG_W       = $clog2(SEGMENTS);
    localparam int ACC_W       = 32;
    localparam int INDEX_W     = 6;
    localparam int VECTOR_DEPTH_DEF = 4096;
    localparam int RECIP_NUM_BITS   = 2 * FRAC_BITS;

    localparam logic [1:0] ACT_MAP    = 2'd0;
    localparam logic [1:0] ACT_COEF   = 2'd1;
    localparam logic [1:0] ACT_SAMPLE = 2'd2;
    localparam logic [1:0] ACT_EMIT   = 2'd3;

    localparam logic [1:0] CFG_X_MIN = 2'd0;
    localparam logic [1:0] CFG_X_MAX = 2'd1;
    localparam logic [1:0] CFG_MODE  = 2'd2;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic signed [ACC_W-1:0]  acc_t;

endpackage

>>> hdl/pfsu_ram.sv
module pfsu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/pfsu_recip.sv
module pfsu_recip (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  pfsu_pkg::acc_t sum,
    output logic          done,
    output pfsu_pkg::acc_t recip,
    output logic          zero
);
    import pfsu_pkg::*;

    localparam int QW = RECIP_NUM_BITS + 1;
    localparam int CNT_W = $clog2(QW);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic              neg_reg, neg_next;
    logic              zero_reg, zero_next;
    logic [ACC_W-1:0]  mag_reg, mag_next;
    logic [ACC_W-1:0]  rem_reg, rem_next;
    logic [QW-1:0]     q_reg, q_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    acc_t              recip_reg, recip_next;
    logic [ACC_W:0]    trial;
    logic              nbit;
    logic [QW-1:0]     q_step;
    logic [ACC_W-1:0]  rem_step;
    logic [ACC_W-1:0]  q_adj;

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        neg_next   = neg_reg;
        zero_next  = zero_reg;
        mag_next   = mag_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        cnt_next   = cnt_reg;
        recip_next = recip_reg;
        // The numerator is a single one bit at the top, so only the first step shifts it in.
        nbit = (cnt_reg == CNT_W'(QW - 1));
        trial = {rem_reg, nbit};
        if (trial >= {1'b0, mag_reg})
        begin
            rem_step = ACC_W'(trial - {1'b0, mag_reg});
            q_step   = {q_reg[QW-2:0], 1'b1};
        end
        else
        begin
            rem_step = trial[ACC_W-1:0];
            q_step   = {q_reg[QW-2:0], 1'b0};
        end
        q_adj = ACC_W'(q_step) + ACC_W'(rem_step != '0);
        if (start)
        begin
            if (sum == '0)
            begin
                recip_next = '0;
                zero_next  = 1'b1;
                done_next  = 1'b1;
            end
            else
            begin
                zero_next = 1'b0;
                neg_next  = sum[ACC_W-1];
                mag_next  = sum[ACC_W-1] ? ACC_W'(-sum) : ACC_W'(sum);
                rem_next  = '0;
                q_next    = '0;
                cnt_next  = CNT_W'(QW - 1);
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            rem_next = rem_step;
            q_next   = q_step;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next  = 1'b0;
                done_next  = 1'b1;
                recip_next = neg_reg ? acc_t'(-q_adj) : acc_t'(ACC_W'(q_step));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            neg_reg   <= 1'b0;
            zero_reg  <= 1'b0;
            mag_reg   <= '0;
            rem_reg   <= '0;
            q_reg     <= '0;
            cnt_reg   <= '0;
            recip_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            neg_reg   <= neg_next;
            zero_reg  <= zero_next;
            mag_reg   <= mag_next;
            rem_reg   <= rem_next;
            q_reg     <= q_next;
            cnt_reg   <= cnt_next;
            recip_reg <= recip_next;
        end
    end

    assign done  = done_reg;
    assign recip = recip_reg;
    assign zero  = zero_reg;

endmodule

>>> hdl/pwl_function_softmax_unit_top.sv
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    action, table_index, map_segment, breakpoint,
//                                             slope, intercept, sample, sample_last
// out       output     out_valid / out_ready  result_value, result_last, fault
// cfg       input      cfg_write              cfg_index, cfg_data
//
// Table loads and softmax samples other than the last leave the unit idle; a pointwise
// sample passes states EVA, EVB, EVC, EVD through the map memory, the coefficient memories and
// the multiplier. An emit does a vector memory read, then the multiply into the output register.
// The last softmax sample starts a walk of states WRD, WX, EVA, EVB, EVC, EVD per stored
// element, then a reciprocal divider, one quotient bit per cycle; no item is taken meanwhile.
// Reset clears the control state; memories are not cleared and must be loaded before use.
// A result waiting in the output register stalls only the item that would replace it.
module pwl_function_softmax_unit_top #(
    parameter int VECTOR_DEPTH = pfsu_pkg::VECTOR_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [1:0]                       action,
    input  logic [pfsu_pkg::INDEX_W-1:0]     table_index,
    input  logic [pfsu_pkg::SEG_W-1:0]       map_segment,
    input  pfsu_pkg::data_t                  breakpoint,
    input  pfsu_pkg::data_t                  slope,
    input  pfsu_pkg::data_t                  intercept,
    input  pfsu_pkg::data_t                  sample,
    input  logic                             sample_last,
    output logic                             out_valid,
    input  logic                             out_ready,
    output pfsu_pkg::data_t                  result_value,
    output logic                             result_last,
    output logic                             fault,
    input  logic                             cfg_write,
    input  logic [1:0]                       cfg_index,
    input  logic [pfsu_pkg::DATA_W-1:0]      cfg_data
);
    import pfsu_pkg::*;

    localparam int AW = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;
    localparam int CW = $clog2(VECTOR_DEPTH + 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_EVA  = 4'd1;
    localparam logic [3:0] S_EVB  = 4'd2;
    localparam logic [3:0] S_EVC  = 4'd3;
    localparam logic [3:0] S_EVD  = 4'd4;
    localparam logic [3:0] S_WRD  = 4'd5;
    localparam logic [3:0] S_WX   = 4'd6;
    localparam logic [3:0] S_DIV  = 4'd7;
    localparam logic [3:0] S_EM   = 4'd8;

    logic [3:0]  state_reg, state_next;
    data_t       x_min_reg, x_min_next;
    data_t       x_max_reg, x_max_next;
    logic        mode_reg, mode_next;
    data_t       x_reg, x_next;
    data_t       xc_reg, xc_next;
    acc_t        prod_reg, prod_next;
    data_t       b_reg, b_next;
    logic        walk_reg, walk_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] walk_idx_reg, walk_idx_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    data_t       max_reg, max_next;
    acc_t        sum_reg, sum_next;
    acc_t        recip_reg, recip_next;
    logic        vec_ready_reg, vec_ready_next;
    logic        ovf_reg, ovf_next;
    logic        fault_reg, fault_next;
    logic        out_valid_reg, out_valid_next;
    data_t       out_value_reg, out_value_next;
    logic        out_last_reg, out_last_next;
    logic        out_fault_reg, out_fault_next;

    logic        accept;
    logic        slot_free;
    data_t       xc;
    data_t       offset;
    logic [COARSE_W-1:0] coarse;
    logic [MAP_AW-1:0]   map_idx;
    data_t       diff;
    acc_t        ev_prod;
    acc_t        y;
    logic signed [DATA_W+ACC_W-1:0] em_prod;
    logic [CW-1:0] cnt_eff;
    data_t       max_eff;

    logic                 seg_we;
    logic [SEG_W-1:0]     seg_rdata;
    logic                 coef_we;
    logic [DATA_W-1:0]    x0_rdata, m_rdata, b_rdata;
    logic                 store_we;
    logic [AW-1:0]        store_waddr, store_raddr;
    logic [DATA_W-1:0]    store_wdata, store_rdata;
    logic                 div_start, div_done, div_zero;
    acc_t                 div_recip;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign slot_free = !out_valid_reg || out_ready;

    // Clamp and segment map index.
    always_comb
    begin
        if (x_reg > x_max_reg)
        begin
            xc = x_max_reg;
        end
        else if (x_reg < x_min_reg)
        begin
            xc = x_min_reg;
        end
        else
        begin
            xc = x_reg;
        end
        offset = xc - x_min_reg;
        coarse = offset[DATA_W-1:IDX_SHIFT];
        if (coarse > COARSE_W'(MAP_ENTRIES - 1))
        begin
            map_idx = MAP_AW'(MAP_ENTRIES - 1);
        end
        else
        begin
            map_idx = coarse[MAP_AW-1:0];
        end
    end

    assign diff    = data_t'(xc_reg - data_t'(x0_rdata));
    assign ev_prod = $signed(m_rdata) * diff;
    assign y       = (prod_reg >>> FRAC_BITS) + acc_t'(b_reg);
    assign em_prod = $signed(store_rdata) * recip_reg;

    assign seg_we  = accept && (action == ACT_MAP) && (int'(table_index) < MAP_ENTRIES);
    assign coef_we = accept && (action == ACT_COEF) && (int'(table_index) < SEGMENTS);

    assign store_raddr = (state_reg == S_WRD) ? walk_idx_reg[AW-1:0] : ptr_reg[AW-1:0];
    assign div_start   = (state_reg == S_WRD) && (walk_idx_reg == count_reg);

    assign cnt_eff = vec_ready_reg ? '0 : count_reg;
    assign max_eff = vec_ready_reg ? data_t'({1'b1, {(DATA_W-1){1'b0}}}) : max_reg;

    always_comb
    begin
        state_next     = state_reg;
        x_min_next     = x_min_reg;
        x_max_next     = x_max_reg;
        mode_next      = mode_reg;
        x_next         = x_reg;
        xc_next        = xc_reg;
        prod_next      = prod_reg;
        b_next         = b_reg;
        walk_next      = walk_reg;
        count_next     = count_reg;
        walk_idx_next  = walk_idx_reg;
        ptr_next       = ptr_reg;
        max_next       = max_reg;
        sum_next       = sum_reg;
        recip_next     = recip_reg;
        vec_ready_next = vec_ready_reg;
        ovf_next       = ovf_reg;
        fault_next     = fault_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;
        out_fault_next = out_fault_reg;
        store_we       = 1'b0;
        store_waddr    = walk_idx_reg[AW-1:0];
        store_wdata    = y[DATA_W-1:0];

        if (cfg_write)
        begin
            case (cfg_index)
                CFG_X_MIN: x_min_next = data_t'(cfg_data);
                CFG_X_MAX: x_max_next = data_t'(cfg_data);
                CFG_MODE:  mode_next  = cfg_data[0];
                default:   ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept && (action == ACT_SAMPLE))
                begin
                    if (!mode_reg)
                    begin
                        x_next     = sample;
                        walk_next  = 1'b0;
                        state_next = S_EVA;
                    end
                    else
                    begin
                        // A sample after a finished vector opens a new one.
                        if (vec_ready_reg)
                        begin
                            vec_ready_next = 1'b0;
                            ovf_next       = 1'b0;
                            fault_next     = 1'b0;
                            sum_next       = '0;
                            ptr_next       = '0;
                        end
                        count_next = cnt_eff;
                        max_next   = max_eff;
                        if (cnt_eff < CW'(VECTOR_DEPTH))
                        begin
                            store_we    = 1'b1;
                            store_waddr = cnt_eff[AW-1:0];
                            store_wdata = sample;
                            count_next  = cnt_eff + 1'b1;
                            if (sample > max_eff)
                            begin
                                max_next = sample;
                            end
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                        if (sample_last)
                        begin
                            walk_idx_next = '0;
                            sum_next      = '0;
                            walk_next     = 1'b1;
                            state_next    = S_WRD;
                        end
                    end
                end
                else if (accept && (action == ACT_EMIT))
                begin
                    if (vec_ready_reg && (ptr_reg < count_reg))
                    begin
                        state_next = S_EM;
                    end
                end
            end
            S_EVA:
            begin
                xc_next    = xc;
                state_next = S_EVB;
            end
            S_EVB:
            begin
                state_next = S_EVC;
            end
            S_EVC:
            begin
                prod_next  = ev_prod;
                b_next     = data_t'(b_rdata);
                state_next = S_EVD;
            end
            S_EVD:
            begin
                if (walk_reg)
                begin
                    store_we      = 1'b1;
                    sum_next      = sum_reg + y;
                    walk_idx_next = walk_idx_reg + 1'b1;
                    state_next    = S_WRD;
                end
                else if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = y[DATA_W-1:0];
                    out_last_next  = 1'b0;
                    out_fault_next = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            S_WRD:
            begin
                if (walk_idx_reg == count_reg)
                begin
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_WX;
                end
            end
            S_WX:
            begin
                x_next     = data_t'(data_t'(store_rdata) - max_reg);
                state_next = S_EVA;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    recip_next     = div_recip;
                    fault_next     = ovf_reg || div_zero;
                    vec_ready_next = 1'b1;
                    ptr_next       = '0;
                    state_next     = S_IDLE;
                end
            end
            S_EM:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = em_prod[FRAC_BITS+DATA_W-1:FRAC_BITS];
                    out_last_next  = (ptr_reg + 1'b1 == count_reg);
                    out_fault_next = fault_reg;
                    ptr_next       = ptr_reg + 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            x_min_reg     <= data_t'({1'b1, {(DATA_W-1){1'b0}}});
            x_max_reg     <= data_t'({1'b0, {(DATA_W-1){1'b1}}});
            mode_reg      <= 1'b0;
            walk_reg      <= 1'b0;
            count_reg     <= '0;
            walk_idx_reg  <= '0;
            ptr_reg       <= '0;
            max_reg       <= data_t'({1'b1, {(DATA_W-1){1'b0}}});
            sum_reg       <= '0;
            recip_reg     <= '0;
            vec_ready_reg <= 1'b0;
            ovf_reg       <= 1'b0;
            fault_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            x_min_reg     <= x_min_next;
            x_max_reg     <= x_max_next;
            mode_reg      <= mode_next;
            walk_reg      <= walk_next;
            count_reg     <= count_next;
            walk_idx_reg  <= walk_idx_next;
            ptr_reg       <= ptr_next;
            max_reg       <= max_next;
            sum_reg       <= sum_next;
            recip_reg     <= recip_next;
            vec_ready_reg <= vec_ready_next;
            ovf_reg       <= ovf_next;
            fault_reg     <= fault_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg         <= x_next;
        xc_reg        <= xc_next;
        prod_reg      <= prod_next;
        b_reg         <= b_next;
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
        out_fault_reg <= out_fault_next;
    end

    pfsu_ram #(.WIDTH(SEG_W), .DEPTH(MAP_ENTRIES)) u_seg_ram (
        .clk   (clk),
        .we    (seg_we),
        .waddr (table_index[MAP_AW-1:0]),
        .wdata (map_segment),
        .raddr (map_idx),
        .rdata (seg_rdata)
    );

    pfsu_ram #(.WIDTH(DATA_W), .DEPTH(SEGMENTS)) u_origin_ram (
        .clk   (clk),
        .we    (coef_we),
        .waddr (table_index[SEG_W-1:0]),
        .wdata (breakpoint),
        .raddr (seg_rdata),
        .rdata (x0_rdata)
    );

    pfsu_ram #(.WIDTH(DATA_W), .DEPTH(SEGMENTS)) u_slope_ram (
        .clk   (clk),
        .we    (coef_we),
        .waddr (table_index[SEG_W-1:0]),
        .wdata (slope),
        .raddr (seg_rdata),
        .rdata (m_rdata)
    );

    pfsu_ram #(.WIDTH(DATA_W), .DEPTH(SEGMENTS)) u_intercept_ram (
        .clk   (clk),
        .we    (coef_we),
        .waddr (table_index[SEG_W-1:0]),
        .wdata (intercept),
        .raddr (seg_rdata),
        .rdata (b_rdata)
    );

    pfsu_ram #(.WIDTH(DATA_W), .DEPTH(VECTOR_DEPTH)) u_vector_ram (
        .clk   (clk),
        .we    (store_we),
        .waddr (store_waddr),
        .wdata (store_wdata),
        .raddr (store_raddr),
        .rdata (store_rdata)
    );

    pfsu_recip u_recip (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .sum   (sum_reg),
        .done  (div_done),
        .recip (div_recip),
        .zero  (div_zero)
    );

    assign out_valid    = out_valid_reg;
    assign result_value = out_value_reg;
    assign result_last  = out_last_reg;
    assign fault        = out_fault_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(VECTOR_DEPTH))
        else $error("element count beyond vector depth");

    a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vec_ready_reg |-> ptr_reg <= count_reg)
        else $error("emit pointer beyond element count");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        walk_reg && state_reg != S_IDLE |-> walk_idx_reg <= count_reg)
        else $error("walk index beyond element count");

    a_ready_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(vec_ready_reg) |-> ptr_reg == '0)
        else $error("vector finished with nonzero emit pointer");

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import pfsu_pkg::*;

    localparam int VDEPTH = VECTOR_DEPTH_DEF;

    typedef struct packed {
        logic [1:0]         act;
        logic [INDEX_W-1:0] idx;
        logic [SEG_W-1:0]   seg;
        logic [15:0]        bp;
        logic [15:0]        sl;
        logic [15:0]        ic;
        logic [15:0]        smp;
        logic               lst;
    } txn_t;

    typedef struct packed {
        logic [15:0] value;
        logic        last;
        logic        flt;
    } res_t;

    typedef struct packed {
        txn_t        t;
        logic        typed;
        logic [15:0] value;
    } row_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [1:0] action;
    logic [INDEX_W-1:0] table_index;
    logic [SEG_W-1:0] map_segment;
    data_t breakpoint;
    data_t slope;
    data_t intercept;
    data_t sample;
    logic sample_last;
    logic out_valid;
    logic out_ready;
    data_t result_value;
    logic result_last;
    logic fault;
    logic cfg_write;
    logic [1:0] cfg_index;
    logic [DATA_W-1:0] cfg_data;

    pwl_function_softmax_unit_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .action(action), .table_index(table_index), .map_segment(map_segment),
        .breakpoint(breakpoint), .slope(slope), .intercept(intercept),
        .sample(sample), .sample_last(sample_last),
        .out_valid(out_valid), .out_ready(out_ready),
        .result_value(result_value), .result_last(result_last), .fault(fault),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Shadow copy of the unit's tables and vector state.
    logic [SEG_W-1:0] seg_map [MAP_ENTRIES];
    data_t org_tab [SEGMENTS];
    data_t slp_tab [SEGMENTS];
    data_t icp_tab [SEGMENTS];
    data_t vec_mem [VDEPTH];
    data_t run_max;
    acc_t  recip;
    int    elem_cnt;
    int    emit_ptr;
    bit    vec_rdy;
    bit    vec_ovf;
    bit    vec_flt;
    data_t x_lo;
    data_t x_hi;
    bit    sm_mode;

    res_t pending_results[$];
    int   errors;
    int   items_sent;
    int   burst_left;
    bit   no_gaps;
    bit   hold_req;
    bit   rx_quiet;

    initial begin
        clk = 1'b0;
        forever begin
            #5 clk = 1'b1;
            #5 clk = 1'b0;
        end
    end

    initial begin
        #5ms;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic acc_t pwl_value(input data_t x);
        data_t xc;
        logic [15:0] off;
        int row;
        logic [SEG_W-1:0] sg;
        data_t d;
        longint p;
        acc_t y;
        xc = (x > x_hi) ? x_hi : ((x < x_lo) ? x_lo : x);
        off = xc - x_lo;
        row = int'(off >> IDX_SHIFT);
        if (row > MAP_ENTRIES - 1)
            row = MAP_ENTRIES - 1;
        sg = seg_map[row];
        d = xc - org_tab[sg];
        p = longint'(slp_tab[sg]) * longint'(d);
        y = (p >>> FRAC_BITS) + longint'(icp_tab[sg]);
        return y;
    endfunction

    // Walk the stored vector once the last sample arrives.
    function automatic void close_vector();
        acc_t sum;
        acc_t y;
        data_t d;
        longint q;
        sum = '0;
        for (int i = 0; i < elem_cnt; i++) begin
            d = vec_mem[i] - run_max;
            y = pwl_value(d);
            vec_mem[i] = y[15:0];
            sum = sum + y;
        end
        vec_flt = vec_ovf;
        if (sum == 0) begin
            recip = '0;
            vec_flt = 1'b1;
        end
        else begin
            q = (64'sd1 << RECIP_NUM_BITS) / longint'(sum);
            if (((64'sd1 << RECIP_NUM_BITS) % longint'(sum)) != 0 && sum < 0)
                q = q - 1;
            recip = q[31:0];
        end
        emit_ptr = 0;
        vec_rdy = 1'b1;
    endfunction

    function automatic bit predict(input txn_t t, output res_t r);
        acc_t y;
        longint p;
        r = '0;
        case (t.act)
            ACT_MAP: begin
                seg_map[t.idx] = t.seg;
                return 0;
            end
            ACT_COEF: begin
                if (t.idx < SEGMENTS) begin
                    org_tab[t.idx] = t.bp;
                    slp_tab[t.idx] = t.sl;
                    icp_tab[t.idx] = t.ic;
                end
                return 0;
            end
            ACT_SAMPLE: begin
                if (!sm_mode) begin
                    y = pwl_value(t.smp);
                    r.value = y[15:0];
                    return 1;
                end
                if (vec_rdy) begin
                    vec_rdy = 1'b0;
                    elem_cnt = 0;
                    emit_ptr = 0;
                    run_max = 16'sh8000;
                    vec_ovf = 1'b0;
                    vec_flt = 1'b0;
                end
                if (elem_cnt < VDEPTH) begin
                    vec_mem[elem_cnt] = t.smp;
                    elem_cnt++;
                    if (run_max < data_t'(t.smp))
                        run_max = t.smp;
                end
                else
                    vec_ovf = 1'b1;
                if (t.lst)
                    close_vector();
                return 0;
            end
            default: begin
                if (!vec_rdy || emit_ptr >= elem_cnt)
                    return 0;
                p = longint'(vec_mem[emit_ptr]) * longint'(recip);
                p = p >>> FRAC_BITS;
                r.value = p[15:0];
                r.last = (emit_ptr + 1 == elem_cnt);
                r.flt = vec_flt;
                emit_ptr++;
                return 1;
            end
        endcase
    endfunction

    // Offers one transaction; unless no_gaps is set, a gap between bursts is inserted first.
    task automatic send(input txn_t t, input bit typed = 0, input logic [15:0] typed_val = '0);
        res_t r;
        bit has;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (!no_gaps) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        action <= t.act;
        table_index <= t.idx;
        map_segment <= t.seg;
        breakpoint <= t.bp;
        slope <= t.sl;
        intercept <= t.ic;
        sample <= t.smp;
        sample_last <= t.lst;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
        has = predict(t, r);
        if (typed) begin
            r.value = typed_val;
            has = 1'b1;
        end
        if (has)
            pending_results.push_back(r);
    endtask

    // Drains all results and lets any table walk finish.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] which, input logic [15:0] val);
        cfg_write <= 1'b1;
        cfg_index <= which;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (which)
            CFG_X_MIN: x_lo = val;
            CFG_X_MAX: x_hi = val;
            default: sm_mode = val[0];
        endcase
    endtask

    function automatic txn_t mk(input logic [1:0] a, input logic [15:0] s = 0, input bit l = 0);
        txn_t t;
        t = txn_t'({$urandom, $urandom, $urandom, $urandom});
        t.act = a;
        t.smp = s;
        t.lst = l;
        return t;
    endfunction

    function automatic txn_t coef(input int k, input logic [15:0] b,
                                  input logic [15:0] m, input logic [15:0] c);
        txn_t t;
        t = mk(ACT_COEF);
        t.idx = k;
        t.bp = b;
        t.sl = m;
        t.ic = c;
        return t;
    endfunction

    function automatic txn_t mapent(input int e, input int s);
        txn_t t;
        t = mk(ACT_MAP);
        t.idx = e;
        t.seg = s;
        return t;
    endfunction

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return $urandom_range(0, 255) - 128;
            default: return $urandom;
        endcase
    endfunction

    // Zero coefficients, or random ones kept small so that softmax sums are mostly nonzero.
    task automatic load_all_coefs(input bit zero);
        for (int k = 0; k < SEGMENTS; k++) begin
            if (zero)
                send(coef(k, 0, 0, 0));
            else
                send(coef(k, $urandom, $urandom_range(0, 2047) - 1024,
                          $urandom_range(0, 4095)));
        end
    endtask

    task automatic run_vector(input int len, input int extra_emits);
        for (int i = 0; i < len; i++)
            send(mk(ACT_SAMPLE, (len > 64) ? $urandom_range(0, 63) : rand_sample(),
                    i == len - 1));
        for (int i = 0; i < len + extra_emits; i++)
            send(mk(ACT_EMIT));
    endtask

    always @(posedge clk) begin
        res_t want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0)
                report("unexpected transaction", result_value, 0);
            else begin
                want = pending_results.pop_front();
                if (result_value !== want.value)
                    report("result_value", result_value, want.value);
                if (result_last !== want.last)
                    report("result_last", result_last, want.last);
                if (fault !== want.flt)
                    report("fault", fault, want.flt);
            end
        end
    end

    initial begin
        int run;
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            if (hold_req) begin
                out_ready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_req = 1'b0;
            end
            else begin
                run = $urandom_range(1, 16);
                stall = rx_quiet ? 0 : $urandom_range(0, 5);
                out_ready <= 1'b1;
                repeat (run) @(posedge clk);
                if (stall != 0) begin
                    out_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
        end
    end

    row_t directed [$];

    initial begin
        row_t rw;
        txn_t t;
        int len;
        rst_n = 1'b0;
        in_valid = 1'b0;
        action = ACT_MAP;
        table_index = '0;
        map_segment = '0;
        breakpoint = '0;
        slope = '0;
        intercept = '0;
        sample = '0;
        sample_last = 1'b0;
        cfg_write = 1'b0;
        cfg_index = CFG_X_MIN;
        cfg_data = '0;
        errors = 0;
        items_sent = 0;
        burst_left = 0;
        no_gaps = 0;
        hold_req = 0;
        rx_quiet = 0;
        x_lo = 16'sh8000;
        x_hi = 16'sh7FFF;
        sm_mode = 0;
        run_max = 16'sh8000;
        recip = '0;
        elem_cnt = 0;
        emit_ptr = 0;
        vec_rdy = 0;
        vec_ovf = 0;
        vec_flt = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every table entry is defined before anything reads it.
        for (int e = 0; e < MAP_ENTRIES; e++)
            send(mapent(e, 0));
        for (int k = 0; k < SEGMENTS; k++)
            send(coef(k, 0, 0, {k[7:0], k[7:0]}));

        // Directed rows: flat segments have readable answers.
        directed.push_back('{mk(ACT_EMIT), 1'b0, 16'h0});
        directed.push_back('{mk(ACT_SAMPLE, 16'h8000), 1'b1, 16'h0000});
        directed.push_back('{mapent(63, 5), 1'b0, 16'h0});
        directed.push_back('{mk(ACT_SAMPLE, 16'h7FFF), 1'b1, 16'h0505});
        directed.push_back('{coef(5, 16'h8000, 16'h7FFF, 16'h7FFF), 1'b0, 16'h0});
        directed.push_back('{mk(ACT_SAMPLE, 16'h7FFF), 1'b0, 16'h0});
        directed.push_back('{coef(5, 16'h7FFF, 16'h8000, 16'h8000), 1'b0, 16'h0});
        directed.push_back('{mk(ACT_SAMPLE, 16'h7FFF), 1'b0, 16'h0});
        directed.push_back('{mk(ACT_SAMPLE, 16'h0000), 1'b0, 16'h0});
        directed.push_back('{coef(63, 0, 0, 16'hFFFF), 1'b0, 16'h0});
        directed.push_back('{mapent(63, 15), 1'b0, 16'h0});
        directed.push_back('{mk(ACT_SAMPLE, 16'h7FFF), 1'b1, 16'h0F0F});
        directed.push_back('{coef(15, 16'hFFFF, 16'hFFFF, 16'h0000), 1'b0, 16'h0});
        directed.push_back('{mk(ACT_SAMPLE, 16'h7FFF), 1'b0, 16'h0});
        directed.push_back('{mk(ACT_EMIT), 1'b0, 16'h0});
        foreach (directed[i]) begin
            rw = directed[i];
            send(rw.t, rw.typed, rw.value);
        end
        drain();

        // Clamp window, including the extreme and crossed bounds.
        write_reg(CFG_X_MIN, 16'hFF9C);
        write_reg(CFG_X_MAX, 16'h0064);
        send(mk(ACT_SAMPLE, 16'h8000));
        send(mk(ACT_SAMPLE, 16'h7FFF));
        drain();
        write_reg(CFG_X_MIN, 16'h7FFF);
        write_reg(CFG_X_MAX, 16'h8000);
        send(mk(ACT_SAMPLE, 16'h0000));
        send(mk(ACT_SAMPLE, 16'h7FFF));
        drain();
        write_reg(CFG_X_MIN, 16'h8000);
        write_reg(CFG_X_MAX, 16'h7FFF);

        // Receiver holds off while pointwise samples keep coming.
        hold_req = 1'b1;
        for (int i = 0; i < 30; i++)
            send(mk(ACT_SAMPLE, rand_sample()));
        drain();

        // Softmax: one element, then a vector whose sum is zero.
        write_reg(CFG_MODE, 16'h0001);
        run_vector(1, 1);
        load_all_coefs(1);
        run_vector(3, 0);
        drain();
        load_all_coefs(0);
        // A vector larger than the store: the extra sample is dropped.
        rx_quiet = 1'b1;
        no_gaps = 1'b1;
        run_vector(VDEPTH + 1, 1);
        drain();
        rx_quiet = 1'b0;
        no_gaps = 1'b0;

        while (items_sent < 1400 + 2 * VDEPTH) begin
            no_gaps = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            drain();
            if ($urandom_range(0, 1) == 0) begin
                write_reg(CFG_MODE, 16'h0000);
                case ($urandom_range(0, 3))
                    0: begin
                        write_reg(CFG_X_MIN, 16'h8000);
                        write_reg(CFG_X_MAX, 16'h7FFF);
                    end
                    default: begin
                        write_reg(CFG_X_MIN, $urandom);
                        write_reg(CFG_X_MAX, $urandom);
                    end
                endcase
                for (int i = 0; i < 40; i++) begin
                    case ($urandom_range(0, 9))
                        0: send(mapent($urandom_range(0, 63), $urandom_range(0, 15)));
                        1: send(coef($urandom_range(0, 63), $urandom, $urandom, $urandom));
                        2: send(mk(ACT_EMIT));
                        default: send(mk(ACT_SAMPLE, rand_sample()));
                    endcase
                end
            end
            else begin
                write_reg(CFG_MODE, 16'h0001);
                write_reg(CFG_X_MIN, 16'h8000);
                write_reg(CFG_X_MAX, 16'h7FFF);
                if ($urandom_range(0, 2) == 0)
                    load_all_coefs(0);
                for (int v = 0; v < 4; v++) begin
                    len = $urandom_range(1, 10);
                    if ($urandom_range(0, 4) == 0) begin
                        // Noise: an emit inside an open vector and a table load.
                        send(mk(ACT_SAMPLE, rand_sample()));
                        send(mk(ACT_EMIT));
                        send(mapent($urandom_range(0, 63), $urandom_range(0, 15)));
                        send(mk(ACT_SAMPLE, rand_sample(), 1'b1));
                        send(mk(ACT_EMIT));
                    end
                    run_vector(len, $urandom_range(0, 1));
                end
            end
        end

        drain();
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
